FILE: hdl/crafill_pkg.sv
package crafill_pkg;

    localparam int PIX_BITS        = 32;
    localparam int SURF_BITS       = 13;
    localparam int RECT_BITS       = 16;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 32;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_MAX_HEIGHT  = 4096;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [SURF_BITS-1:0] RESET_SURFACE_WIDTH  = 13'd640;
    localparam logic [SURF_BITS-1:0] RESET_SURFACE_HEIGHT = 13'd480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SURFACE_WIDTH  = 3'd0,
        REG_SURFACE_HEIGHT = 3'd1,
        REG_RECT_LEFT      = 3'd2,
        REG_RECT_TOP       = 3'd3,
        REG_RECT_WIDTH     = 3'd4,
        REG_RECT_HEIGHT    = 3'd5,
        REG_FILL_COLOR     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [SURF_BITS-1:0]        surface_width;
        logic [SURF_BITS-1:0]        surface_height;
        logic signed [RECT_BITS-1:0] rect_left;
        logic signed [RECT_BITS-1:0] rect_top;
        logic signed [RECT_BITS-1:0] rect_width;
        logic signed [RECT_BITS-1:0] rect_height;
        logic [PIX_BITS-1:0]         fill_color;
    } cfg_t;

    // Word handed from the classifier to the blend pipeline.
    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                do_blend;
        logic                end_of_frame;
    } item_t;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] x1;
        logic [16:0] s;
        x1 = {1'b0, x} + 17'd1;
        s  = x1 + {8'd0, x1[16:8]};
        return s[15:8];
    endfunction

endpackage

FILE: hdl/crafill_front.sv
module crafill_front
    import crafill_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                push,
    input  logic                full,
    input  logic [PIX_BITS-1:0] pixel_in,
    input  logic                frame_start,
    output logic                wr_en,
    output item_t               wr_item
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int EWW = (WW > SURF_BITS) ? WW : SURF_BITS;
    localparam int EHW = (HW > SURF_BITS) ? HW : SURF_BITS;
    localparam int AWW = (CW + 1 > WW) ? CW + 1 : WW;
    localparam int AHW = (RW + 1 > HW) ? RW + 1 : HW;
    localparam int MW  = (WW > HW) ? WW : HW;
    localparam int SW  = ((MW > RECT_BITS) ? MW : RECT_BITS) + 2;

    logic [CW-1:0] col_reg, col_next, col_cur;
    logic [RW-1:0] row_reg, row_next, row_cur;

    logic [EWW-1:0] sw_ext;
    logic [EHW-1:0] sh_ext;
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;

    logic signed [SW-1:0] x0, y0, x1_sum, y1_sum, x1, y1, w_s, h_s, col_s, row_s;
    logic                 in_rect;
    logic [CW:0]          col_inc;
    logic [RW:0]          row_inc;
    logic                 col_wrap, row_wrap;
    logic                 accept;

    assign accept = push && !full;

    // Clamp the surface size into 1 .. max.
    always_comb
    begin
        sw_ext = EWW'(cfg.surface_width);
        sh_ext = EHW'(cfg.surface_height);
        if (sw_ext == '0)
            w_eff = WW'(1);
        else if (sw_ext > EWW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(sw_ext);
        if (sh_ext == '0)
            h_eff = HW'(1);
        else if (sh_ext > EHW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(sh_ext);
    end

    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;

    // Clip the rectangle against the surface in a width that cannot overflow.
    always_comb
    begin
        w_s     = SW'($signed({1'b0, w_eff}));
        h_s     = SW'($signed({1'b0, h_eff}));
        col_s   = SW'($signed({1'b0, col_cur}));
        row_s   = SW'($signed({1'b0, row_cur}));
        x0      = cfg.rect_left[RECT_BITS-1] ? '0 : SW'(cfg.rect_left);
        y0      = cfg.rect_top[RECT_BITS-1]  ? '0 : SW'(cfg.rect_top);
        x1_sum  = SW'(cfg.rect_left) + SW'(cfg.rect_width);
        y1_sum  = SW'(cfg.rect_top)  + SW'(cfg.rect_height);
        x1      = (x1_sum > w_s) ? w_s : x1_sum;
        y1      = (y1_sum > h_s) ? h_s : y1_sum;
        in_rect = (col_s >= x0) && (col_s < x1) && (row_s >= y0) && (row_s < y1);
    end

    // Advance the position, wrapping at the clamped size.
    always_comb
    begin
        col_inc  = {1'b0, col_cur} + (CW+1)'(1);
        row_inc  = {1'b0, row_cur} + (RW+1)'(1);
        col_wrap = AWW'(col_inc) >= AWW'(w_eff);
        row_wrap = AHW'(row_inc) >= AHW'(h_eff);
        col_next = col_wrap ? '0 : col_inc[CW-1:0];
        row_next = row_cur;
        if (col_wrap)
        begin
            row_next = row_wrap ? '0 : row_inc[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign wr_en                = accept;
    assign wr_item.pixel        = pixel_in;
    assign wr_item.do_blend     = in_rect && (cfg.fill_color[31:24] != 8'd0);
    assign wr_item.end_of_frame = (AWW'(col_cur) == AWW'(w_eff - WW'(1)))
                               && (AHW'(row_cur) == AHW'(h_eff - HW'(1)));

    a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_start && (w_eff > WW'(1)))
        |=> (col_reg == CW'(1)) && (row_reg == '0))
        else $error("frame_start did not restart the position at the origin");

endmodule

FILE: hdl/crafill_queue.sv
module crafill_queue
    import crafill_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  item_t wr_item,
    output logic  full,
    input  logic  rd_en,
    output item_t rd_item,
    output logic  rd_valid
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign full     = (count_reg == NW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + NW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - NW'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + NW'(1)))
        else $error("queue count did not grow on a lone write");

endmodule

FILE: hdl/crafill_back.sv
module crafill_back
    import crafill_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PIX_BITS-1:0] fill_color,
    input  logic                q_valid,
    input  item_t               q_item,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output logic [PIX_BITS-1:0] pixel_out,
    output logic                end_of_frame
);

    logic [7:0] alpha, alpha_inv;

    // Stage 1: products
    logic                s1_valid_reg;
    logic                s1_blend_reg;
    logic                s1_eof_reg;
    logic [PIX_BITS-1:0] s1_pixel_reg;
    logic [15:0]         s1_sum_reg [4];
    logic [15:0]         sum_next [4];
    logic                s1_ready;

    // Stage 2: result word
    logic                out_valid_reg;
    logic [PIX_BITS-1:0] out_pixel_reg;
    logic                out_eof_reg;
    logic [PIX_BITS-1:0] blended;
    logic                out_ready;

    assign alpha     = fill_color[31:24];
    assign alpha_inv = 8'd255 - alpha;
    assign out_ready = !out_valid_reg || pop;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign q_rd      = q_valid && s1_ready;

    // Channels 0..2 are blue, green, red; entry 3 is the alpha term.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k] = {8'd0, fill_color[8*k +: 8]} * {8'd0, alpha}
                        + {8'd0, q_item.pixel[8*k +: 8]} * {8'd0, alpha_inv};
        end
        sum_next[3] = {8'd0, 8'd255 - q_item.pixel[31:24]} * {8'd0, alpha};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            s1_blend_reg <= q_item.do_blend;
            s1_eof_reg   <= q_item.end_of_frame;
            s1_pixel_reg <= q_item.pixel;
            for (int k = 0; k < 4; k++)
                s1_sum_reg[k] <= sum_next[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            blended[8*k +: 8] = div255(s1_sum_reg[k]);
        blended[31:24] = s1_pixel_reg[31:24] + div255(s1_sum_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_ready)
        begin
            out_pixel_reg <= s1_blend_reg ? blended : s1_pixel_reg;
            out_eof_reg   <= s1_eof_reg;
        end
    end

    assign empty        = !out_valid_reg;
    assign pixel_out    = out_pixel_reg;
    assign end_of_frame = out_eof_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("blend stage dropped a word while stalled");

endmodule

FILE: hdl/clipped_rect_alpha_fill_top.sv
// Path: a pushed pixel is written to the queue, then registered in the product stage,
// then in the output register that drives the result ports.
// Throughput: one pixel per clock unless stalled; each channel's multiply and
// divide-by-255 run in their own stage; the queue decouples input and output stalls.
// Reset: registers return to 640x480, empty rectangle, zero color; the position
// counters clear to the origin and the queue and pipeline come up empty.
module clipped_rect_alpha_fill_top
    import crafill_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [PIX_BITS-1:0]       pixel_in,
    input  logic                      frame_start,
    input  logic                      pop,
    output logic                      empty,
    output logic [PIX_BITS-1:0]       pixel_out,
    output logic                      end_of_frame,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  wr_en;
    item_t wr_item;
    logic  q_rd;
    item_t q_item;
    logic  q_valid;

    assign cfg_ready = 1'b1;

    // Unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.surface_width  <= RESET_SURFACE_WIDTH;
            cfg_reg.surface_height <= RESET_SURFACE_HEIGHT;
            cfg_reg.rect_left      <= '0;
            cfg_reg.rect_top       <= '0;
            cfg_reg.rect_width     <= '0;
            cfg_reg.rect_height    <= '0;
            cfg_reg.fill_color     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SURFACE_WIDTH:  cfg_reg.surface_width  <= cfg_data[SURF_BITS-1:0];
                REG_SURFACE_HEIGHT: cfg_reg.surface_height <= cfg_data[SURF_BITS-1:0];
                REG_RECT_LEFT:      cfg_reg.rect_left      <= cfg_data[RECT_BITS-1:0];
                REG_RECT_TOP:       cfg_reg.rect_top       <= cfg_data[RECT_BITS-1:0];
                REG_RECT_WIDTH:     cfg_reg.rect_width     <= cfg_data[RECT_BITS-1:0];
                REG_RECT_HEIGHT:    cfg_reg.rect_height    <= cfg_data[RECT_BITS-1:0];
                REG_FILL_COLOR:     cfg_reg.fill_color     <= cfg_data[PIX_BITS-1:0];
                default:            ;
            endcase
        end
    end

    crafill_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .pixel_in    (pixel_in),
        .frame_start (frame_start),
        .wr_en       (wr_en),
        .wr_item     (wr_item)
    );

    crafill_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_item  (wr_item),
        .full     (full),
        .rd_en    (q_rd),
        .rd_item  (q_item),
        .rd_valid (q_valid)
    );

    crafill_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fill_color   (cfg_reg.fill_color),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .pixel_out    (pixel_out),
        .end_of_frame (end_of_frame)
    );

endmodule

FILE: tb/sv/tb_clipped_rect_alpha_fill_top.sv
module tb_clipped_rect_alpha_fill_top;
    import crafill_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PIXELS = 1150;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                eof;
    } fill_result_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      push        = 1'b0;
    logic                      full;
    logic [PIX_BITS-1:0]       pixel_in    = '0;
    logic                      frame_start = 1'b0;
    logic                      pop         = 1'b0;
    logic                      empty;
    logic [PIX_BITS-1:0]       pixel_out;
    logic                      end_of_frame;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;

    // Shadow copy of the register file and the raster position
    logic [SURF_BITS-1:0]        surf_w    = RESET_SURFACE_WIDTH;
    logic [SURF_BITS-1:0]        surf_h    = RESET_SURFACE_HEIGHT;
    logic signed [RECT_BITS-1:0] rect_l    = '0;
    logic signed [RECT_BITS-1:0] rect_t    = '0;
    logic signed [RECT_BITS-1:0] rect_w    = '0;
    logic signed [RECT_BITS-1:0] rect_h    = '0;
    logic [PIX_BITS-1:0]         fill_argb = '0;
    int                          col_pos   = 0;
    int                          row_pos   = 0;

    fill_result_t expected_fills[$];
    int           errors       = 0;
    int           stall_cycles = 0;
    bit           steady       = 1'b0;

    clipped_rect_alpha_fill_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_in     (pixel_in),
        .frame_start  (frame_start),
        .pop          (pop),
        .empty        (empty),
        .pixel_out    (pixel_out),
        .end_of_frame (end_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_size(input logic [SURF_BITS-1:0] v, input int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic int channel_mix(input int s, input int d, input int a);
        return (s * a + d * (255 - a)) / 255;
    endfunction

    function automatic logic [PIX_BITS-1:0] blend_over(input logic [PIX_BITS-1:0] dst,
                                                       input logic [PIX_BITS-1:0] color);
        int a;
        int da;
        int oa;
        int r;
        int g;
        int b;
        a  = int'(color[31:24]);
        da = int'(dst[31:24]);
        oa = da + (255 - da) * a / 255;
        r  = channel_mix(int'(color[23:16]), int'(dst[23:16]), a);
        g  = channel_mix(int'(color[15:8]), int'(dst[15:8]), a);
        b  = channel_mix(int'(color[7:0]), int'(dst[7:0]), a);
        return {oa[7:0], r[7:0], g[7:0], b[7:0]};
    endfunction

    // Work out the output word for one pixel and advance the raster position
    function automatic fill_result_t predict_fill(input logic [PIX_BITS-1:0] pix,
                                                  input logic fs);
        fill_result_t res;
        int           w;
        int           h;
        int           x0;
        int           x1;
        int           y0;
        int           y1;
        w = clamp_size(surf_w, DEF_MAX_WIDTH);
        h = clamp_size(surf_h, DEF_MAX_HEIGHT);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x0 = (rect_l < 0) ? 0 : int'(rect_l);
        y0 = (rect_t < 0) ? 0 : int'(rect_t);
        x1 = int'(rect_l) + int'(rect_w);
        y1 = int'(rect_t) + int'(rect_h);
        if (x1 > w)
            x1 = w;
        if (y1 > h)
            y1 = h;
        res.pixel = pix;
        if (fill_argb[31:24] != 8'd0 && x1 > x0 && y1 > y0 &&
            col_pos >= x0 && col_pos < x1 && row_pos >= y0 && row_pos < y1)
            res.pixel = blend_over(pix, fill_argb);
        res.eof = (col_pos == w - 1 && row_pos == h - 1);
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
        return res;
    endfunction

    task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic fs);
        cfg_valid <= 1'b0;
        while (!steady && $urandom_range(0, 99) < 34)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        pixel_in    <= pix;
        frame_start <= fs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_fills.push_back(predict_fill(pix, fs));
    endtask

    // Caller must hold push low; registers change only while the pipe is empty
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SURFACE_WIDTH:  surf_w    = data[SURF_BITS-1:0];
            REG_SURFACE_HEIGHT: surf_h    = data[SURF_BITS-1:0];
            REG_RECT_LEFT:      rect_l    = data[RECT_BITS-1:0];
            REG_RECT_TOP:       rect_t    = data[RECT_BITS-1:0];
            REG_RECT_WIDTH:     rect_w    = data[RECT_BITS-1:0];
            REG_RECT_HEIGHT:    rect_h    = data[RECT_BITS-1:0];
            REG_FILL_COLOR:     fill_argb = data;
            default:            ;
        endcase
    endtask

    task automatic drain_results();
        push      <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (expected_fills.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SURF_BITS-1:0] pick_size(input int typical);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        if (k == 1)
            return SURF_BITS'($urandom_range(4096, 8191));
        return SURF_BITS'($urandom_range(1, typical));
    endfunction

    function automatic logic [RECT_BITS-1:0] pick_edge(input int lo, input int hi);
        int v;
        if ($urandom_range(0, 9) == 0)
            return RECT_BITS'($urandom_range(0, 65535));
        v = int'($urandom_range(0, hi - lo)) + lo;
        return v[RECT_BITS-1:0];
    endfunction

    // Reset state: empty rectangle, so everything passes through
    task automatic test_reset_values();
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
    endtask

    task automatic test_small_frame_blend();
        logic [PIX_BITS-1:0] frame_pix [12] = '{
            32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080,
            32'hA5A5_5A5A, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0102_0304,
            32'h7F00_FF01, 32'hDEAD_BEEF, 32'h0F0F_F0F0, 32'hC3C3_3C3C};
        drain_results();
        write_reg(REG_SURFACE_WIDTH, 32'd4);
        write_reg(REG_SURFACE_HEIGHT, 32'd3);
        write_reg(REG_RECT_LEFT, 32'd1);
        write_reg(REG_RECT_TOP, 32'd1);
        write_reg(REG_RECT_WIDTH, 32'd2);
        // taller than the surface: clip at the bottom
        write_reg(REG_RECT_HEIGHT, 32'd5);
        write_reg(REG_FILL_COLOR, 32'h80FF_007F);
        for (int i = 0; i < 12; i++)
            send_pixel(frame_pix[i], i == 0);
        // wrap back to the origin without a frame start
        send_pixel(32'h5555_AAAA, 1'b0);
    endtask

    task automatic test_size_edge_cases();
        drain_results();
        write_reg(REG_SURFACE_WIDTH, 32'hFFFF_E000);
        write_reg(REG_SURFACE_HEIGHT, 32'd2);
        write_reg(REG_RECT_LEFT, 32'hFFFF_FFFE);
        write_reg(REG_RECT_WIDTH, 32'd3);
        write_reg(REG_RECT_TOP, 32'hFFFF_FFFF);
        write_reg(REG_RECT_HEIGHT, 32'd2);
        write_reg(REG_FILL_COLOR, 32'h00AB_CDEF);
        send_pixel(32'h0000_FFFF, 1'b1);
        send_pixel(32'hFFFF_0000, 1'b0);
        drain_results();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(REG_FILL_COLOR, 32'hFF00_FF00);
        send_pixel(32'h1234_5678, 1'b1);
        send_pixel(32'h00FF_00FF, 1'b0);
        drain_results();
        // rectangle far outside the surface on both axes
        write_reg(REG_SURFACE_HEIGHT, 32'hFFFF_FFFF);
        write_reg(REG_RECT_LEFT, 32'h0000_8000);
        write_reg(REG_RECT_WIDTH, 32'h0000_7FFF);
        write_reg(REG_RECT_TOP, 32'h0000_7FFF);
        write_reg(REG_RECT_HEIGHT, 32'h0000_7FFF);
        send_pixel(32'h8765_4321, 1'b1);
        send_pixel(32'hFEDC_BA98, 1'b0);
    endtask

    task automatic test_random_frames();
        int                  sent;
        int                  ew;
        int                  eh;
        int                  span_w;
        int                  span_h;
        int                  frame_len;
        int                  npix;
        int                  k;
        bit                  resume;
        bit                  noisy;
        logic [PIX_BITS-1:0] color;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            drain_results();
            steady = (sent >= 400 && sent < 650);
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_SURFACE_WIDTH,
                          ($urandom & 32'hFFFF_E000) | CFG_DATA_BITS'(pick_size(12)));
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_SURFACE_HEIGHT,
                          ($urandom & 32'hFFFF_E000) | CFG_DATA_BITS'(pick_size(8)));
            ew     = clamp_size(surf_w, DEF_MAX_WIDTH);
            eh     = clamp_size(surf_h, DEF_MAX_HEIGHT);
            span_w = (ew > 16) ? 16 : ew;
            span_h = (eh > 16) ? 16 : eh;
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_RECT_LEFT, ($urandom & 32'hFFFF_0000)
                          | CFG_DATA_BITS'(pick_edge(-4, span_w + 2)));
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_RECT_WIDTH, ($urandom & 32'hFFFF_0000)
                          | CFG_DATA_BITS'(pick_edge(-3, span_w + 6)));
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_RECT_TOP, ($urandom & 32'hFFFF_0000)
                          | CFG_DATA_BITS'(pick_edge(-4, span_h + 2)));
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_RECT_HEIGHT, ($urandom & 32'hFFFF_0000)
                          | CFG_DATA_BITS'(pick_edge(-3, span_h + 6)));
            if ($urandom_range(0, 9) < 7)
            begin
                color = $urandom;
                k     = $urandom_range(0, 9);
                if (k < 2)
                    color[31:24] = 8'h00;
                else if (k < 4)
                    color[31:24] = 8'hFF;
                write_reg(REG_FILL_COLOR, color);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, $urandom);
            // resume keeps the old position, so a shrunken size forces a wrap
            resume = (sent > 0 && $urandom_range(0, 4) == 0);
            noisy  = ($urandom_range(0, 6) == 0);
            if (ew * eh <= 96)
            begin
                frame_len = ew * eh;
                npix      = frame_len * $urandom_range(1, 2);
            end
            else
            begin
                frame_len = $urandom_range(5, 40);
                npix      = frame_len;
            end
            for (int i = 0; i < npix; i++)
                send_pixel($urandom, (i % frame_len == 0 && !(resume && i == 0)) ||
                                     (noisy && $urandom_range(0, 15) == 0));
            sent += npix;
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        fill_result_t want;
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
            begin
                if (pop && !empty)
                begin
                    if (expected_fills.size() == 0)
                    begin
                        $display("%0t: unexpected word: pixel_out %h end_of_frame %b",
                                 $time, pixel_out, end_of_frame);
                        errors++;
                    end
                    else
                    begin
                        want = expected_fills.pop_front();
                        if (pixel_out !== want.pixel)
                        begin
                            $display("%0t: pixel_out expected %h actual %h",
                                     $time, want.pixel, pixel_out);
                            errors++;
                        end
                        if (end_of_frame !== want.eof)
                        begin
                            $display("%0t: end_of_frame expected %b actual %b",
                                     $time, want.eof, end_of_frame);
                            errors++;
                        end
                    end
                end
                pop <= steady || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_small_frame_blend();
        test_size_edge_cases();
        test_random_frames();
        drain_results();
        repeat (8)
            @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
